// File: rtl/bmp24_nearest_preview_sampler_unit_assert.svh
// Assertion macros for the BMP preview sampler.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef BMP24_NEAREST_PREVIEW_SAMPLER_UNIT_ASSERT_SVH
`define BMP24_NEAREST_PREVIEW_SAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BNPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BNPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bnps_pkg.sv
// Shared constants and types of the BMP preview sampler.
// No dependencies; used by the request interface and all modules.
`default_nettype none

package bnps_pkg;

    // Preview size; both must be powers of two
    localparam int PREVIEW_WIDTH  = 128;
    localparam int PREVIEW_HEIGHT = 128;
    localparam int PV_W_SHIFT     = $clog2(PREVIEW_WIDTH);
    localparam int PV_H_SHIFT     = $clog2(PREVIEW_HEIGHT);

    // File store
    localparam int STORE_BYTES = 262144;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int SIZE_W      = 19;

    // Datapath widths: dimensions are kept only when they fit below 2^DIM_W
    localparam int DIM_W  = ADDR_W + 1;
    localparam int PROD_W = 2 * DIM_W;

    // Header layout
    localparam int HDR_BYTES  = 54;
    localparam int HDR_CACHE  = 30;
    localparam int HDR_IDX_W  = $clog2(HDR_CACHE);
    localparam int BPP_24     = 24;
    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_M = 8'h4D;

    // Request types
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;
    localparam logic [1:0] ST_TRUNC  = 2'd3;

    // Decoded header, size-independent part
    typedef struct packed {
        logic              sig_ok;
        logic              fmt_bad;
        logic              top_first;
        logic              dim_ovf;
        logic [31:0]       offset;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  stride;
    } hdr_info_t;

endpackage

`default_nettype wire

// File: rtl/bnps_req_if.sv
// Request channel of the BMP preview sampler: valid/ready plus payload.
// Depends on bnps_pkg.
`default_nettype none

interface bnps_req_if;
    import bnps_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] byte_addr;
    logic [7:0]        byte_value;
    logic [6:0]        out_x;
    logic [6:0]        out_y;

    modport source (
        output valid, req_type, byte_addr, byte_value, out_x, out_y,
        input  ready
    );

    modport sink (
        input  valid, req_type, byte_addr, byte_value, out_x, out_y,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/bnps_rsp_if.sv
// Result channel of the BMP preview sampler: valid/ready plus pixel and status.
// Depends on nothing outside this file.
`default_nettype none

interface bnps_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;

    modport source (
        output valid, red, green, blue, status,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, status,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/bnps_store.sv
// Single-port byte store holding the loaded file, registered read data.
// Depends on bnps_pkg.
`default_nettype none

module bnps_store (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [bnps_pkg::ADDR_W-1:0] addr,
    input  wire logic [7:0]                wdata,
    output logic [7:0]                     rdata
);
    import bnps_pkg::*;

    logic [7:0] mem [0:STORE_BYTES-1];
    logic [7:0] rdata_reg;

    // Write on load, read the same address every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/bnps_hdr.sv
// Header shadow: snoops loads into the first header bytes and decodes them.
// Depends on bnps_pkg; feeds the sequencer in the top level.
`default_nettype none

module bnps_hdr (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [bnps_pkg::ADDR_W-1:0] addr,
    input  wire logic [7:0]                wdata,
    output bnps_pkg::hdr_info_t            info
);
    import bnps_pkg::*;

    logic [7:0]  hdr_b [0:HDR_CACHE-1];
    hdr_info_t   info_reg;

    logic [31:0] offset;
    logic [31:0] wraw;
    logic [31:0] hraw;
    logic [15:0] bpp;
    logic        top_first;
    logic [31:0] height32;
    logic [33:0] stride34;
    logic        height_ovf;
    logic        stride_ovf;

    // Capture header bytes as they are loaded
    always_ff @(posedge clk)
    begin
        if (we && (addr < ADDR_W'(HDR_CACHE)))
        begin
            hdr_b[addr[HDR_IDX_W-1:0]] <= wdata;
        end
    end

    // Assemble little-endian fields and derive row geometry
    always_comb
    begin
        offset     = {hdr_b[13], hdr_b[12], hdr_b[11], hdr_b[10]};
        wraw       = {hdr_b[21], hdr_b[20], hdr_b[19], hdr_b[18]};
        hraw       = {hdr_b[25], hdr_b[24], hdr_b[23], hdr_b[22]};
        bpp        = {hdr_b[29], hdr_b[28]};
        top_first  = hraw[31];
        height32   = top_first ? (~hraw + 32'd1) : hraw;
        stride34   = ({2'b00, wraw} + {1'b0, wraw, 1'b0} + 34'd3) & ~34'd3;
        height_ovf = |height32[31:DIM_W];
        stride_ovf = |stride34[33:DIM_W];
    end

    // Register the decode so the sequencer sees a short path
    always_ff @(posedge clk)
    begin
        info_reg.sig_ok    <= (hdr_b[0] == CHAR_B) && (hdr_b[1] == CHAR_M);
        info_reg.fmt_bad   <= (wraw == 32'd0) || wraw[31] || (height32 == 32'd0)
                              || height32[31] || (bpp != 16'(BPP_24));
        info_reg.top_first <= top_first;
        info_reg.dim_ovf   <= height_ovf || stride_ovf;
        info_reg.offset    <= offset;
        info_reg.width     <= wraw[DIM_W-1:0];
        info_reg.height    <= height32[DIM_W-1:0];
        info_reg.stride    <= stride34[DIM_W-1:0];
    end

    assign info = info_reg;

endmodule

`default_nettype wire

// File: rtl/bnps_mul.sv
// Shared multiplier of the sampler: one registered product per enabled cycle.
// Depends on bnps_pkg.
`default_nettype none

module bnps_mul (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [bnps_pkg::DIM_W-1:0] a,
    input  wire logic [bnps_pkg::DIM_W-1:0] b,
    output logic [bnps_pkg::PROD_W-1:0]     prod
);
    import bnps_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // Multiply and hold the product until the next use
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: rtl/bmp24_nearest_preview_sampler_unit.sv
// BMP preview sampler top level: sequencer around one shared multiplier.
// A load transfer leaves the block idle, so it is ready again for the next request.
// A fetch runs header and truncation checks, scaling and row products on the shared
// multiplier, three reads of the single-port store and the handoff to the result
// register; the next request is taken once the block is idle again. Bad header or
// format: handoff after the header check; truncated: after the truncation check. A stalled result holds it.
`default_nettype none
`include "bmp24_nearest_preview_sampler_unit_assert.svh"

module bmp24_nearest_preview_sampler_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    bnps_req_if.sink                        req,
    bnps_rsp_if.source                      rsp,
    input  wire logic                       cfg_we,
    input  wire logic [bnps_pkg::SIZE_W-1:0] cfg_wdata
);
    import bnps_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_TRUNC = 4'd2;
    localparam logic [3:0] S_SY    = 4'd3;
    localparam logic [3:0] S_SX    = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_ADDR  = 4'd6;
    localparam logic [3:0] S_RD0   = 4'd7;
    localparam logic [3:0] S_RD1   = 4'd8;
    localparam logic [3:0] S_RD2   = 4'd9;
    localparam logic [3:0] S_RD3   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [SIZE_W-1:0] fsize_reg;

    logic [6:0]        px_reg;
    logic [6:0]        py_reg;
    logic [DIM_W-1:0]  sy_reg;
    logic [DIM_W-1:0]  sx_reg;
    logic [DIM_W-1:0]  row_reg;
    logic [DIM_W-1:0]  offset_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        red_reg;
    logic [7:0]        green_reg;
    logic [7:0]        blue_reg;
    logic [1:0]        status_reg;

    logic              out_valid_reg;
    logic [7:0]        out_red_reg;
    logic [7:0]        out_green_reg;
    logic [7:0]        out_blue_reg;
    logic [1:0]        out_status_reg;

    hdr_info_t         hdr;
    logic              load_acc;
    logic              fetch_acc;
    logic              out_free;
    logic              rsp_load;
    logic              rgb_zero;
    logic [SIZE_W-1:0] size_c;
    logic              bad_hdr;
    logic              bad_fmt;
    logic              trunc;
    logic [PROD_W:0]   end_sum;
    logic [DIM_W+1:0]  sx3;
    logic [DIM_W+1:0]  addr_sum;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_rdata;
    logic              mul_en;
    logic [DIM_W-1:0]  mul_a;
    logic [DIM_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    // Handshakes
    assign req.ready = (state_reg == S_IDLE);
    assign load_acc  = req.valid && req.ready && (req.req_type == REQ_LOAD);
    assign fetch_acc = req.valid && req.ready && (req.req_type == REQ_FETCH);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp_load  = (state_reg == S_DONE) && out_free;
    assign rgb_zero  = (rsp.red == 8'd0) && (rsp.green == 8'd0) && (rsp.blue == 8'd0);

    // Header checks that depend on the configured size
    always_comb
    begin
        size_c  = (fsize_reg > SIZE_W'(STORE_BYTES)) ? SIZE_W'(STORE_BYTES)
                                                     : fsize_reg;
        bad_hdr = (size_c < SIZE_W'(HDR_BYTES)) || !hdr.sig_ok;
        bad_fmt = hdr.fmt_bad || (hdr.offset >= 32'(size_c));
        end_sum = (PROD_W+1)'(offset_reg) + (PROD_W+1)'(prod);
        trunc   = hdr.dim_ovf || (end_sum > (PROD_W+1)'(size_c));
        sx3     = (DIM_W+2)'(sx_reg) + (DIM_W+2)'({sx_reg, 1'b0});
        addr_sum = (DIM_W+2)'(offset_reg) + (DIM_W+2)'(prod[DIM_W-1:0]) + sx3;
    end

    // Route operands to the shared multiplier
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = hdr.stride;
        mul_b  = hdr.height;
        case (state_reg)
            S_CHECK:
            begin
                mul_en = 1'b1;
            end
            S_TRUNC:
            begin
                mul_en = 1'b1;
                mul_a  = DIM_W'(py_reg);
            end
            S_SY:
            begin
                mul_en = 1'b1;
                mul_a  = DIM_W'(px_reg);
                mul_b  = hdr.width;
            end
            S_ROW:
            begin
                mul_en = 1'b1;
                mul_a  = row_reg;
                mul_b  = hdr.stride;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Store address: loads write, the read states walk the pixel bytes
    always_comb
    begin
        case (state_reg)
            S_RD1:   mem_addr = addr_reg + ADDR_W'(1);
            S_RD2:   mem_addr = addr_reg + ADDR_W'(2);
            S_IDLE:  mem_addr = req.byte_addr;
            default: mem_addr = addr_reg;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (fetch_acc)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (bad_hdr || bad_fmt) ? S_DONE : S_TRUNC;
            end
            S_TRUNC:
            begin
                state_next = trunc ? S_DONE : S_SY;
            end
            S_SY:    state_next = S_SX;
            S_SX:    state_next = S_ROW;
            S_ROW:   state_next = S_ADDR;
            S_ADDR:  state_next = S_RD0;
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fsize_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                fsize_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                // Saturate coordinates past the preview edge
                px_reg <= (int'(req.out_x) >= PREVIEW_WIDTH) ? 7'(PREVIEW_WIDTH - 1)
                                                             : req.out_x;
                py_reg <= (int'(req.out_y) >= PREVIEW_HEIGHT) ? 7'(PREVIEW_HEIGHT - 1)
                                                              : req.out_y;
            end
            S_CHECK:
            begin
                offset_reg <= hdr.offset[DIM_W-1:0];
                red_reg    <= '0;
                green_reg  <= '0;
                blue_reg   <= '0;
                status_reg <= bad_hdr ? ST_BAD : ST_FORMAT;
            end
            S_TRUNC:
            begin
                status_reg <= ST_TRUNC;
            end
            S_SY:
            begin
                sy_reg <= DIM_W'(prod >> PV_H_SHIFT);
            end
            S_SX:
            begin
                sx_reg  <= DIM_W'(prod >> PV_W_SHIFT);
                row_reg <= hdr.top_first ? sy_reg : (hdr.height - DIM_W'(1) - sy_reg);
            end
            S_ADDR:
            begin
                addr_reg <= addr_sum[ADDR_W-1:0];
            end
            S_RD1:
            begin
                blue_reg <= mem_rdata;
            end
            S_RD2:
            begin
                green_reg <= mem_rdata;
            end
            S_RD3:
            begin
                red_reg    <= mem_rdata;
                status_reg <= ST_OK;
            end
            default:
            begin
                addr_reg <= addr_reg;
            end
        endcase

        // Move the finished result into the output register
        if (rsp_load)
        begin
            out_red_reg    <= red_reg;
            out_green_reg  <= green_reg;
            out_blue_reg   <= blue_reg;
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.red    = out_red_reg;
    assign rsp.green  = out_green_reg;
    assign rsp.blue   = out_blue_reg;
    assign rsp.status = out_status_reg;

    bnps_store u_store (
        .clk   (clk),
        .we    (load_acc),
        .addr  (mem_addr),
        .wdata (req.byte_value),
        .rdata (mem_rdata)
    );

    bnps_hdr u_hdr (
        .clk   (clk),
        .we    (load_acc),
        .addr  (req.byte_addr),
        .wdata (req.byte_value),
        .info  (hdr)
    );

    bnps_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Checks
    `BNPS_ASSERT_NEXT(a_fetch_starts, fetch_acc, state_reg == S_CHECK, "fetch did not start")
    `BNPS_ASSERT_NEXT(a_load_stays, load_acc, state_reg == S_IDLE, "load left the idle state")
    `BNPS_ASSERT_NOW(a_err_black, rsp.valid && (rsp.status != ST_OK), rgb_zero, "error color")
    `BNPS_ASSERT_NEXT(a_done_loads, rsp_load, rsp.valid && (state_reg == S_IDLE), "result lost")

endmodule

`default_nettype wire

// File: sim/tb_bmp24_nearest_preview_sampler_unit.sv
`timescale 1ns / 100ps
// Testbench for the BMP preview sampler: loads small 24-bit BMP images through the
// request channel and checks every fetched preview pixel against a local sampler model or a directed status.
// Depends on bnps_pkg, bnps_req_if, bnps_rsp_if and bmp24_nearest_preview_sampler_unit.

module tb_bmp24_nearest_preview_sampler_unit;
    import bnps_pkg::*;

    // Written image area: header plus pixel rows, loaded once before the first image
    localparam int REGION        = 320;
    localparam int RANDOM_ITEMS  = 120;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int NUM_PROBES    = 25;

    // Header byte positions
    localparam int OFS_POS = 10;
    localparam int WID_POS = 18;
    localparam int HGT_POS = 22;
    localparam int BPP_POS = 28;

    localparam logic [63:0] STORE_LIM  = 64'(STORE_BYTES);
    localparam logic [31:0] DIM_NEG    = 32'h8000_0000;
    localparam logic [15:0] BPP_RGB    = 16'(BPP_24);
    localparam logic [18:0] SIZE_MAX   = 19'h7FFFF;
    localparam logic [7:0]  CHAR_N     = 8'h4E;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] status;
    } pixel_t;

    typedef struct packed {
        logic        hdr;
        logic [18:0] fsize;
        logic [7:0]  sig0;
        logic [7:0]  sig1;
        logic [31:0] ofs;
        logic [31:0] wid;
        logic [31:0] hgt;
        logic [15:0] bpp;
        logic [6:0]  x;
        logic [6:0]  y;
        logic        typed;
        logic [1:0]  st;
    } probe_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    bnps_req_if req_ch ();
    bnps_rsp_if rsp_ch ();

    bmp24_nearest_preview_sampler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Local copy of the store and of the size register
    logic [7:0]  file_mirror [0:STORE_BYTES-1];
    bit          loaded      [0:STORE_BYTES-1];
    logic [18:0] mirror_size = '0;
    bit          region_filled = 1'b0;

    pixel_t expected_pixels [$];

    int  mismatches   = 0;
    int  sent_items   = 0;
    int  cycle_count  = 0;
    int  pending_gap  = 0;
    int  rx_quiet     = 0;
    bit  valid_hi     = 1'b0;
    bit  sender_burst = 1'b0;

    // Directed probes: header errors, size limits, corners of the preview
    probe_row_t probe_rows [NUM_PROBES] = '{
        '{1'b0, 19'd0,      CHAR_B, CHAR_M, 32'd54,  32'd8,  32'd8,  BPP_RGB, 7'd0,   7'd0,
          1'b1, ST_BAD},
        '{1'b1, 19'd53,     CHAR_B, CHAR_M, 32'd54,  32'd8,  32'd8,  BPP_RGB, 7'd5,   7'd5,
          1'b1, ST_BAD},
        '{1'b1, 19'd320,    CHAR_M, CHAR_B, 32'd54,  32'd8,  32'd8,  BPP_RGB, 7'd1,   7'd1,
          1'b1, ST_BAD},
        '{1'b1, 19'd320,    CHAR_B, CHAR_N, 32'd54,  32'd8,  32'd8,  BPP_RGB, 7'd1,   7'd1,
          1'b1, ST_BAD},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd320, 32'd8,  32'd8,  BPP_RGB, 7'd2,   7'd2,
          1'b1, ST_FORMAT},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd0,  32'd8,  BPP_RGB, 7'd2,   7'd2,
          1'b1, ST_FORMAT},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  DIM_NEG, 32'd8, BPP_RGB, 7'd2,   7'd2,
          1'b1, ST_FORMAT},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd8,  32'd0,  BPP_RGB, 7'd2,   7'd2,
          1'b1, ST_FORMAT},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd8,  DIM_NEG, BPP_RGB, 7'd2,  7'd2,
          1'b1, ST_FORMAT},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd8,  32'd8,  16'd32,  7'd2,   7'd2,
          1'b1, ST_FORMAT},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd8,  32'd8,  16'h0118, 7'd2,  7'd2,
          1'b1, ST_FORMAT},
        '{1'b1, 19'd57,     CHAR_B, CHAR_M, 32'd54,  32'd1,  32'd1,  BPP_RGB, 7'd0,   7'd0,
          1'b1, ST_TRUNC},
        '{1'b1, SIZE_MAX,   CHAR_B, CHAR_M, 32'd54,  32'h7FFF_FFFF, 32'h7FFF_FFFF, BPP_RGB,
          7'd127, 7'd127, 1'b1, ST_TRUNC},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd8,  32'd8,  BPP_RGB, 7'd0,   7'd0,
          1'b0, ST_OK},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd8,  32'd8,  BPP_RGB, 7'd127, 7'd127,
          1'b0, ST_OK},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd8,  -32'sd8, BPP_RGB, 7'd127, 7'd0,
          1'b0, ST_OK},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd8,  -32'sd8, BPP_RGB, 7'd0,  7'd127,
          1'b0, ST_OK},
        '{1'b1, 19'd58,     CHAR_B, CHAR_M, 32'd54,  32'd1,  32'd1,  BPP_RGB, 7'd64,  7'd64,
          1'b0, ST_OK},
        '{1'b1, 19'd64,     CHAR_B, CHAR_M, 32'd0,   32'd5,  32'd4,  BPP_RGB, 7'd100, 7'd33,
          1'b0, ST_OK},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd10,  32'd100, 32'd1, BPP_RGB, 7'd127, 7'd3,
          1'b0, ST_OK},
        '{1'b1, 19'd320,    CHAR_B, CHAR_M, 32'd54,  32'd1,  32'd64, BPP_RGB, 7'd0,   7'd127,
          1'b0, ST_OK},
        '{1'b1, 19'd262144, CHAR_B, CHAR_M, 32'd54,  32'd8,  -32'sd8, BPP_RGB, 7'd85, 7'd42,
          1'b0, ST_OK},
        '{1'b1, 19'd262145, CHAR_B, CHAR_M, 32'd54,  32'd8,  -32'sd8, BPP_RGB, 7'd85, 7'd42,
          1'b0, ST_OK},
        '{1'b1, SIZE_MAX,   CHAR_B, CHAR_M, 32'd54,  32'd3,  -32'sd1, BPP_RGB, 7'd127, 7'd127,
          1'b0, ST_OK},
        '{1'b1, SIZE_MAX,   CHAR_B, CHAR_M, 32'd54,  32'd86, 32'd1,  BPP_RGB, 7'd127, 7'd0,
          1'b0, ST_OK}
    };

    // Clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_pixels.size());
            $display("** bmp24_nearest_preview_sampler_unit: FAILED **");
            $finish;
        end
    end

    // Store byte as the block sees it; beyond the store reads as zero
    function automatic logic [63:0] peek(logic [63:0] a);
        if (a >= STORE_LIM)
            return 64'd0;
        return {56'd0, file_mirror[a[ADDR_W-1:0]]};
    endfunction

    function automatic logic [63:0] peek32(logic [63:0] a);
        return peek(a) | (peek(a + 1) << 8) | (peek(a + 2) << 16) | (peek(a + 3) << 24);
    endfunction

    // Sample one preview pixel from the mirrored file; base returns the first byte read
    function automatic pixel_t sample_preview(logic [6:0] px, logic [6:0] py,
                                              output logic [63:0] base);
        logic [63:0] lim, offset, wraw, hraw, bpp, width, height, stride;
        logic [63:0] cx, cy, sx, sy, row;
        logic        top_first;
        pixel_t      res;
        res  = '0;
        base = '0;
        lim  = 64'(mirror_size);
        if (lim > STORE_LIM)
            lim = STORE_LIM;
        if (lim < 64'(HDR_BYTES) || peek(0) != 64'(CHAR_B) || peek(1) != 64'(CHAR_M))
        begin
            res.status = ST_BAD;
            return res;
        end
        offset    = peek32(OFS_POS);
        wraw      = peek32(WID_POS);
        hraw      = peek32(HGT_POS);
        bpp       = peek(BPP_POS) | (peek(BPP_POS + 1) << 8);
        top_first = hraw[31];
        height    = top_first ? ((64'h1_0000_0000 - hraw) & 64'hFFFF_FFFF) : hraw;
        if (offset >= lim || wraw == 0 || wraw[31] || height == 0 || height[31] ||
            bpp != 64'(BPP_24))
        begin
            res.status = ST_FORMAT;
            return res;
        end
        width  = wraw;
        stride = (width * 3 + 3) & ~64'd3;
        if (offset + stride * height > lim)
        begin
            res.status = ST_TRUNC;
            return res;
        end
        // Saturate to the last preview column and row
        cx = 64'(px);
        cy = 64'(py);
        if (cx >= 64'(PREVIEW_WIDTH))
            cx = 64'(PREVIEW_WIDTH - 1);
        if (cy >= 64'(PREVIEW_HEIGHT))
            cy = 64'(PREVIEW_HEIGHT - 1);
        sy   = (cy * height) / 64'(PREVIEW_HEIGHT);
        sx   = (cx * width) / 64'(PREVIEW_WIDTH);
        row  = top_first ? sy : (height - 1 - sy);
        base = offset + row * stride + sx * 3;
        // Stored order is BGR
        res.red    = 8'(peek(base + 2));
        res.green  = 8'(peek(base + 1));
        res.blue   = 8'(peek(base));
        res.status = ST_OK;
        return res;
    endfunction

    function automatic logic [6:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 7'd0;
            1: return 7'd127;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic note_mismatch(string what, int got_v, int want_v);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
        mismatches++;
    endtask

    // Drive one request and hold it until the transfer
    task automatic send_item(logic kind, logic [ADDR_W-1:0] addr, logic [7:0] val,
                             logic [6:0] x, logic [6:0] y);
        repeat (pending_gap) @(posedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.byte_addr  <= addr;
        req_ch.byte_value <= val;
        req_ch.out_x      <= x;
        req_ch.out_y      <= y;
        valid_hi = 1'b1;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        sent_items++;
        // Keep valid up for a back-to-back transfer, drop it before a gap
        pending_gap = sender_burst ? 0 : $urandom_range(0, 8);
        if (pending_gap != 0)
        begin
            req_ch.valid <= 1'b0;
            valid_hi = 1'b0;
        end
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic wait_idle();
        if (valid_hi)
        begin
            req_ch.valid <= 1'b0;
            valid_hi = 1'b0;
        end
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size_cfg(logic [18:0] v);
        wait_idle();
        cfg_we      <= 1'b1;
        cfg_wdata   <= v;
        mirror_size = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_byte(logic [ADDR_W-1:0] addr, logic [7:0] val);
        file_mirror[addr] = val;
        loaded[addr]      = 1'b1;
        send_item(REQ_LOAD, addr, val, 7'($urandom), 7'($urandom));
    endtask

    // Load only bytes that differ from what the store already holds
    task automatic write_field(int pos, logic [31:0] val, int nbytes);
        int k;
        logic [ADDR_W-1:0] a;
        for (k = 0; k < nbytes; k++)
        begin
            a = ADDR_W'(pos + k);
            if (!loaded[a] || file_mirror[a] != val[8*k +: 8])
                load_byte(a, val[8*k +: 8]);
        end
    endtask

    task automatic put_header(logic [7:0] s0, logic [7:0] s1, logic [31:0] ofs,
                              logic [31:0] wid, logic [31:0] hgt, logic [15:0] bpp);
        int a;
        if (!region_filled)
        begin
            for (a = 0; a < REGION; a++)
                load_byte(ADDR_W'(a), 8'($urandom));
            region_filled = 1'b1;
        end
        write_field(0, {24'd0, s0}, 1);
        write_field(1, {24'd0, s1}, 1);
        write_field(OFS_POS, ofs, 4);
        write_field(WID_POS, wid, 4);
        write_field(HGT_POS, hgt, 4);
        write_field(BPP_POS, {16'd0, bpp}, 2);
    endtask

    // Predict and send one fetch; a fetch that would read unloaded bytes is dropped
    task automatic issue_fetch(logic [6:0] x, logic [6:0] y, bit use_typed, pixel_t typed);
        pixel_t            want;
        logic [63:0]       base;
        logic [ADDR_W-1:0] a;
        want = sample_preview(x, y, base);
        a    = base[ADDR_W-1:0];
        if (want.status == ST_OK && !(loaded[a] && loaded[a + 1] && loaded[a + 2]))
            return;
        if (use_typed)
            want = typed;
        expected_pixels.push_back(want);
        send_item(REQ_FETCH, ADDR_W'($urandom), 8'($urandom), x, y);
    endtask

    // New random header and file size; either a readable image or one of several broken kinds
    task automatic start_phase();
        logic [31:0] ofs, wid, hgt;
        logic [15:0] bpp;
        logic [7:0]  s0, s1;
        logic [18:0] fsize;
        int          stride, rows, foot;
        s0     = CHAR_B;
        s1     = CHAR_M;
        bpp    = BPP_RGB;
        ofs    = $urandom_range(0, 60);
        wid    = $urandom_range(1, 86);
        stride = ((int'(wid) * 3 + 3) / 4) * 4;
        rows   = $urandom_range(1, (REGION - int'(ofs)) / stride);
        foot   = int'(ofs) + stride * rows;
        hgt    = $urandom_range(0, 1) ? 32'(-rows) : 32'(rows);
        fsize  = 19'($urandom_range(foot, REGION));
        case ($urandom_range(0, 11))
            0: fsize = 19'(STORE_BYTES);
            1: fsize = 19'($urandom_range(STORE_BYTES + 1, 32'(SIZE_MAX)));
            2: fsize = 19'($urandom_range(0, foot - 1));
            3: fsize = 19'($urandom_range(0, HDR_BYTES - 1));
            4:
            begin
                s0 = 8'($urandom);
                s1 = 8'($urandom);
            end
            5: ofs = $urandom_range(32'(fsize), 32'hFFFF_FFFF);
            6: wid = $urandom_range(0, 1) ? 32'd0 : {1'b1, 31'($urandom)};
            7: hgt = $urandom_range(0, 1) ? 32'd0 : DIM_NEG;
            8: bpp = 16'($urandom);
            9:
            begin
                wid   = $urandom_range(1, 32'h7FFF_FFFF);
                hgt   = $urandom;
                fsize = 19'($urandom_range(0, 32'(SIZE_MAX)));
            end
            default: ;
        endcase
        set_size_cfg(fsize);
        put_header(s0, s1, ofs, wid, hgt, bpp);
        sender_burst = ($urandom_range(0, 3) == 0);
    endtask

    // Compare one result transfer with the oldest prediction
    task automatic check_pixel();
        pixel_t got, want;
        got.red    = rsp_ch.red;
        got.green  = rsp_ch.green;
        got.blue   = rsp_ch.blue;
        got.status = rsp_ch.status;
        if (expected_pixels.size() == 0)
        begin
            note_mismatch("result with no fetch pending", int'(got), 0);
            return;
        end
        want = expected_pixels.pop_front();
        if (got.status !== want.status)
            note_mismatch("status", int'(got.status), int'(want.status));
        if (got.red !== want.red)
            note_mismatch("red", int'(got.red), int'(want.red));
        if (got.green !== want.green)
            note_mismatch("green", int'(got.green), int'(want.green));
        if (got.blue !== want.blue)
            note_mismatch("blue", int'(got.blue), int'(want.blue));
    endtask

    // Result side: random stalls with stretches of steady ready
    initial
    begin : result_sink
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_quiet == 0 && $urandom_range(0, 3) == 0)
                rx_quiet = $urandom_range(5, 30);
            if (rx_quiet > 0)
            begin
                stall = 0;
                rx_quiet--;
            end
            else
                stall = $urandom_range(0, 8);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            check_pixel();
        end
    end

    // Request side: reset, directed probes, then random phases
    initial
    begin : stimulus
        int     i, n, pick, random_start;
        pixel_t typed;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_LOAD;
        req_ch.byte_addr  <= '0;
        req_ch.byte_value <= '0;
        req_ch.out_x      <= '0;
        req_ch.out_y      <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_PROBES; i++)
        begin
            set_size_cfg(probe_rows[i].fsize);
            if (probe_rows[i].hdr)
                put_header(probe_rows[i].sig0, probe_rows[i].sig1, probe_rows[i].ofs,
                           probe_rows[i].wid, probe_rows[i].hgt, probe_rows[i].bpp);
            typed        = '0;
            typed.status = probe_rows[i].st;
            issue_fetch(probe_rows[i].x, probe_rows[i].y, probe_rows[i].typed, typed);
        end

        random_start = sent_items;
        while (sent_items - random_start < RANDOM_ITEMS)
        begin
            start_phase();
            n = $urandom_range(8, 40);
            repeat (n)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    issue_fetch(pick_coord(), pick_coord(), 1'b0, '0);
                else if (pick < 80)
                    load_byte(ADDR_W'($urandom_range(0, REGION - 1)), 8'($urandom));
                else if (pick < 90)
                    load_byte(ADDR_W'($urandom), 8'($urandom));
                else
                    load_byte(ADDR_W'($urandom_range(0, BPP_POS + 1)), 8'($urandom));
            end
        end

        // Drain and report
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** bmp24_nearest_preview_sampler_unit: PASSED **");
        else
            $display("** bmp24_nearest_preview_sampler_unit: FAILED **");
        $finish;
    end

endmodule
